[hdl/pressure_sensor_compensation_defines.svh]
// Assertion macros shared by the pressure compensation RTL.
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/psc_pkg.sv]
// Shared types and constants of the pressure compensation block.
package psc_pkg;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic        cmd;
        logic [19:0] raw_reading;
    } psc_in_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic               zero_divisor;
    } psc_out_t;

endpackage

[hdl/psc_mul.sv]
// Bit-serial saturating signed 64-bit multiplier.
module psc_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] result
);
    import psc_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] mplier_reg, mplier_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        mc_ovf_reg, mc_ovf_next;
    logic        neg_reg, neg_next;
    logic signed [63:0] result_reg, result_next;
    logic [64:0] sum;
    logic [63:0] lim;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        mc_ovf_next = mc_ovf_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        sum = {1'b0, acc_reg} + {1'b0, mcand_reg};
        lim = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (start)
        begin
            busy_next   = 1'b1;
            mcand_next  = a[63] ? 64'(-a) : 64'(a);
            mplier_next = b[63] ? 64'(-b) : 64'(b);
            acc_next    = '0;
            ovf_next    = 1'b0;
            mc_ovf_next = 1'b0;
            neg_next    = a[63] ^ b[63];
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (ovf_reg || acc_reg > lim)
                    result_next = neg_reg ? S64_MIN : S64_MAX;
                else
                    result_next = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    if (mc_ovf_reg || sum[64])
                        ovf_next = 1'b1;
                    acc_next = sum[63:0];
                end
                // Once a set bit leaves the top, the true multiplicand no longer fits.
                mc_ovf_next = mc_ovf_reg | mcand_reg[63];
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[63:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        ovf_reg    <= ovf_next;
        mc_ovf_reg <= mc_ovf_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;
endmodule

[hdl/psc_div.sv]
// Bit-serial restoring signed 64-bit divider, truncating toward zero.
module psc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] result
);
    import psc_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  count_reg, count_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic signed [63:0] result_reg, result_next;
    logic [64:0] rem_sh;
    logic        qbit;
    logic [63:0] qfin;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dsr_next    = dsr_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        result_next = result_reg;
        rem_sh = {rem_reg[63:0], quo_reg[63]};
        qbit   = rem_sh >= {1'b0, dsr_reg};
        qfin   = {quo_reg[62:0], qbit};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 7'd64;
            rem_next   = '0;
            quo_next   = a[63] ? 64'(-a) : 64'(a);
            dsr_next   = b[63] ? 64'(-b) : 64'(b);
            neg_next   = a[63] ^ b[63];
            zero_next  = (b == '0);
        end
        else if (busy_reg)
        begin
            rem_next   = qbit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            quo_next   = qfin;
            count_next = count_reg - 7'd1;
            if (count_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    result_next = '0;
                else if (neg_reg)
                    result_next = -$signed(qfin);
                else
                    result_next = qfin[63] ? S64_MAX : $signed(qfin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dsr_reg    <= dsr_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;
endmodule

[hdl/pressure_sensor_compensation.sv]
// Top level: calibration registers, micro-step sequencer and output register.
//
// Input channel in_valid/in_ready/in_data carries one raw reading tagged
// temperature (cmd 0) or pressure (cmd 1). Output channel out_valid/out_ready/
// out_data returns one result per transaction: kind, value, zero_divisor.
// Calibration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. Items
// are worked one at a time by a sequencer that runs a fixed list of
// saturating 64-bit steps. An add step writes back as it issues. A multiply
// step issues, shifts once per bit of its second operand's magnitude (0 to
// 64 bits), finishes and writes back. The divide step issues, forms one
// quotient bit per iteration for all 64 bits and writes back. A pressure
// item stops after the divisor step when the divisor is zero. The next input
// transaction can be accepted in the cycle after the result is registered.
// in_ready is high whenever the sequencer is idle, even while a finished
// result still waits in the output register; a stalled receiver holds the
// next result in the sequencer until the output register frees up.
// Reset clears the calibration registers, the fine temperature and all
// control state; there is no clearing pass.
`include "pressure_sensor_compensation_defines.svh"

module pressure_sensor_compensation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psc_pkg::psc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psc_pkg::psc_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import psc_pkg::*;

    localparam logic [1:0] REG_TEMP   = 2'd0;
    localparam logic [1:0] REG_PRESSA = 2'd1;
    localparam logic [1:0] REG_PRESSB = 2'd2;
    localparam logic [1:0] REG_NINE   = 2'd3;

    localparam logic [4:0] TEMP_LAST  = 5'd5;
    localparam logic [4:0] PRESS_LAST = 5'd23;
    localparam logic [4:0] STEP_DIVISOR = 5'd12;
    localparam logic [4:0] STEP_FINE    = 5'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    typedef enum logic [1:0] {OP_ADD, OP_MUL, OP_DIV} op_t;
    typedef enum logic [1:0] {D_A, D_B, D_C, D_D} dst_t;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
        logic signed [63:0] s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63])
            return x[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        return x;
    endfunction

    function automatic logic signed [63:0] sx16(input logic [15:0] f);
        return $signed({{48{f[15]}}, f});
    endfunction

    state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic        cmd_reg, cmd_next;
    logic [19:0] raw_reg, raw_next;
    logic        zdiv_reg, zdiv_next;
    logic signed [63:0] ra_reg, ra_next, rb_reg, rb_next;
    logic signed [63:0] rc_reg, rc_next, rd_reg, rd_next;
    logic [31:0] fine_reg, fine_next;
    logic [47:0] temp_reg;
    logic [63:0] pa_reg, pb_reg;
    logic [15:0] nine_reg;
    logic        out_valid_reg, out_valid_next;
    psc_out_t    out_data_reg, out_data_next;

    op_t  op;
    dst_t dst;
    logic signed [63:0] x, y, res_raw, res, a_ft, d1, d2, p_out;
    logic signed [63:0] res_c32, ra_c32;
    logic [5:0] shamt;
    logic       last;
    logic       wb_en;
    logic       mul_start, mul_busy, mul_done;
    logic       div_start, div_busy, div_done;
    logic signed [63:0] mul_res, div_res;

    assign a_ft = $signed({{32{fine_reg[31]}}, fine_reg}) - 64'sd128000;
    assign d1 = $signed({47'b0, raw_reg[19:3]}) - $signed({47'b0, temp_reg[15:0], 1'b0});
    assign d2 = $signed({48'b0, raw_reg[19:4]}) - $signed({48'b0, temp_reg[15:0]});

    // Step list: operands, operation, destination and floor shift of the result.
    always_comb
    begin
        op    = OP_ADD;
        dst   = D_A;
        x     = '0;
        y     = '0;
        shamt = 6'd0;
        if (!cmd_reg)
        begin
            last = (step_reg == TEMP_LAST);
            case (step_reg)
                5'd0:
                begin
                    op = OP_MUL; x = d1; y = sx16(temp_reg[31:16]); shamt = 6'd11;
                end
                5'd1:
                begin
                    op = OP_MUL; dst = D_B; x = d2; y = d2; shamt = 6'd12;
                end
                5'd2:
                begin
                    op = OP_MUL; dst = D_B; x = rb_reg; y = sx16(temp_reg[47:32]);
                    shamt = 6'd14;
                end
                5'd3:
                begin
                    x = ra_reg; y = rb_reg;
                end
                5'd4:
                begin
                    op = OP_MUL; x = ra_c32; y = 64'sd5;
                end
                default:
                begin
                    x = ra_reg; y = 64'sd128; shamt = 6'd8;
                end
            endcase
        end
        else
        begin
            last = (step_reg == PRESS_LAST);
            case (step_reg)
                5'd0:  begin op = OP_MUL; dst = D_B; x = a_ft; y = a_ft; end
                5'd1:  begin op = OP_MUL; dst = D_C; x = rb_reg; y = sx16(pb_reg[31:16]); end
                5'd2:  begin op = OP_MUL; dst = D_D; x = a_ft; y = sx16(pb_reg[15:0]); end
                5'd3:  begin op = OP_MUL; dst = D_D; x = rd_reg; y = 64'sd1 <<< 17; end
                5'd4:  begin dst = D_C; x = rc_reg; y = rd_reg; end
                5'd5:
                begin
                    op = OP_MUL; dst = D_D; x = sx16(pa_reg[63:48]); y = 64'sd1 <<< 35;
                end
                5'd6:  begin dst = D_C; x = rc_reg; y = rd_reg; end
                5'd7:
                begin
                    op = OP_MUL; dst = D_B; x = rb_reg; y = sx16(pa_reg[47:32]);
                    shamt = 6'd8;
                end
                5'd8:  begin op = OP_MUL; dst = D_D; x = a_ft; y = sx16(pa_reg[31:16]); end
                5'd9:  begin op = OP_MUL; dst = D_D; x = rd_reg; y = 64'sd1 <<< 12; end
                5'd10: begin dst = D_B; x = rb_reg; y = rd_reg; end
                5'd11: begin dst = D_B; x = 64'sd1 <<< 47; y = rb_reg; end
                5'd12:
                begin
                    op = OP_MUL; dst = D_B; x = rb_reg; y = $signed({48'b0, pa_reg[15:0]});
                    shamt = 6'd33;
                end
                5'd13:
                begin
                    op = OP_MUL; dst = D_D;
                    x = 64'sd1048576 - $signed({44'b0, raw_reg}); y = 64'sd1 <<< 31;
                end
                5'd14:
                begin
                    dst = D_D; x = rd_reg;
                    y = (rc_reg == S64_MIN) ? S64_MAX : -rc_reg;
                end
                5'd15: begin op = OP_MUL; dst = D_D; x = rd_reg; y = 64'sd3125; end
                5'd16: begin op = OP_DIV; dst = D_D; x = rd_reg; y = rb_reg; end
                5'd17:
                begin
                    op = OP_MUL; dst = D_C; x = sx16(nine_reg); y = rd_reg >>> 13;
                end
                5'd18:
                begin
                    op = OP_MUL; dst = D_C; x = rc_reg; y = rd_reg >>> 13; shamt = 6'd25;
                end
                5'd19:
                begin
                    op = OP_MUL; dst = D_A; x = sx16(pb_reg[63:48]); y = rd_reg;
                    shamt = 6'd19;
                end
                5'd20: begin dst = D_D; x = rd_reg; y = rc_reg; end
                5'd21: begin dst = D_D; x = rd_reg; y = ra_reg; shamt = 6'd8; end
                5'd22: begin op = OP_MUL; dst = D_C; x = sx16(pb_reg[47:32]); y = 64'sd16; end
                default: begin dst = D_D; x = rd_reg; y = rc_reg; end
            endcase
        end
    end

    assign mul_start = (state_reg == S_ISSUE) && (op == OP_MUL);
    assign div_start = (state_reg == S_ISSUE) && (op == OP_DIV);

    psc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (x),
        .b      (y),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    psc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (x),
        .b      (y),
        .busy   (div_busy),
        .done   (div_done),
        .result (div_res)
    );

    always_comb
    begin
        case (op)
            OP_MUL:  res_raw = mul_res;
            OP_DIV:  res_raw = div_res;
            default: res_raw = sadd(x, y);
        endcase
        res = res_raw >>> shamt;
        wb_en = ((state_reg == S_ISSUE) && (op == OP_ADD)) ||
                ((state_reg == S_WAIT) && (mul_done || div_done));
    end

    assign res_c32 = clamp32(res);
    assign ra_c32  = clamp32(ra_reg);

    always_comb
    begin
        if (rd_reg < 0)
            p_out = '0;
        else if (rd_reg > 64'sd2147483647)
            p_out = 64'sd2147483647;
        else
            p_out = rd_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        raw_next       = raw_reg;
        zdiv_next      = zdiv_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        rd_next        = rd_reg;
        fine_next      = fine_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (wb_en)
        begin
            case (dst)
                D_A:     ra_next = res;
                D_B:     rb_next = res;
                D_C:     rc_next = res;
                default: rd_next = res;
            endcase
            if (!cmd_reg && step_reg == STEP_FINE)
                fine_next = res_c32[31:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.cmd;
                    raw_next   = in_data.raw_reading;
                    step_next  = '0;
                    zdiv_next  = 1'b0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE, S_WAIT:
            begin
                if (state_reg == S_ISSUE && op != OP_ADD)
                    state_next = S_WAIT;
                else if (wb_en)
                begin
                    if (last)
                        state_next = S_FIN;
                    else if (cmd_reg && step_reg == STEP_DIVISOR && res == '0)
                    begin
                        zdiv_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.kind          = cmd_reg;
                    out_data_next.zero_divisor  = zdiv_reg;
                    if (!cmd_reg)
                        out_data_next.value = ra_c32[31:0];
                    else if (zdiv_reg)
                        out_data_next.value = '0;
                    else
                        out_data_next.value = p_out[31:0];
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            zdiv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fine_reg      <= '0;
            temp_reg      <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            nine_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            zdiv_reg      <= zdiv_next;
            out_valid_reg <= out_valid_next;
            fine_reg      <= fine_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP:   temp_reg <= cfg_data[47:0];
                    REG_PRESSA: pa_reg   <= cfg_data;
                    REG_PRESSB: pb_reg   <= cfg_data;
                    REG_NINE:   nine_reg <= cfg_data[15:0];
                    default:    temp_reg <= temp_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        raw_reg      <= raw_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rc_reg       <= rc_next;
        rd_reg       <= rd_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // One item at a time: an accepted transaction closes the input side.
    `PSC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    // A zero divisor only arises on pressure and always forces the value to zero.
    `PSC_ASSERT_NOW(a_zdiv_value, clk, rst_n, out_valid && out_data.zero_divisor,
        out_data.kind && out_data.value == '0)
    // No serial unit is left running once the sequencer is idle.
    `PSC_ASSERT_NOW(a_idle_units, clk, rst_n, state_reg == S_IDLE, !mul_busy && !div_busy)
endmodule
